[rtl/tats_pkg.sv]
package tats_pkg;

  localparam int GLYPHS        = 256;
  localparam int GLYPH_IDX_W   = $clog2(GLYPHS);
  localparam int GW_BITS       = 8;
  localparam int POS_BITS      = 24;
  localparam int ADV_BITS      = 11;
  localparam int CODE_BITS     = 21;
  localparam int TAB_BITS      = 10;
  localparam int OP_BITS       = 2;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int STEP_CNT_W    = $clog2(POS_BITS + 1);

  localparam logic [POS_BITS-1:0]  POS_MAX   = {POS_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] CH_NUL    = CODE_BITS'(0);
  localparam logic [CODE_BITS-1:0] CH_TAB    = CODE_BITS'(9);
  localparam logic [CODE_BITS-1:0] CH_LF     = CODE_BITS'(10);
  localparam logic [CODE_BITS-1:0] CH_CR     = CODE_BITS'(13);
  localparam logic [CODE_BITS-1:0] CH_PLANE1 = CODE_BITS'(65536);

  localparam logic [GW_BITS-1:0]  SPACING_RST = GW_BITS'(1);
  localparam logic [GW_BITS-1:0]  SPACE_RST   = GW_BITS'(8);
  localparam logic [TAB_BITS-1:0] TAB_RST     = TAB_BITS'(32);

  typedef enum logic [OP_BITS-1:0] {
    OP_REGISTER = 2'd0,
    OP_MEASURE  = 2'd1,
    OP_NEWLINE  = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    REG_GLYPH_SPACING  = 2'd0,
    REG_SPACE_ADVANCE  = 2'd1,
    REG_TAB_STOP_WIDTH = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [OP_BITS-1:0]   opcode;
    logic [CODE_BITS-1:0] char_code;
    logic [GW_BITS-1:0]   glyph_width_in;
  } in_item_t;

  typedef struct packed {
    logic [ADV_BITS-1:0] advance;
    logic [POS_BITS-1:0] line_position;
    logic                glyph_known;
    logic                position_overflow;
    logic [GW_BITS-1:0]  widest_width;
  } out_item_t;

  typedef struct packed {
    logic                   rd_en;
    logic [GLYPH_IDX_W-1:0] rd_idx;
    logic                   wr_en;
    logic [GLYPH_IDX_W-1:0] lk_idx;
    logic [GW_BITS-1:0]     wr_width;
  } glyph_req_t;

  typedef struct packed {
    logic                done;
    logic [TAB_BITS-1:0] rem;
  } rem_stat_t;

endpackage

[rtl/tats_glyph_store.sv]
module tats_glyph_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tats_pkg::glyph_req_t        req_i,
  output logic [tats_pkg::GW_BITS-1:0] rd_width_o,
  output logic                        lk_valid_o
);
  import tats_pkg::*;

  logic [GW_BITS-1:0] width_mem [GLYPHS];
  logic [GW_BITS-1:0] rd_width_q;
  logic [GLYPHS-1:0]  valid_q;

  // Width store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      width_mem[req_i.lk_idx] <= req_i.wr_width;
    end
    if (req_i.rd_en) begin
      rd_width_q <= width_mem[req_i.rd_idx];
    end
  end

  // Presence bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en) begin
      valid_q[req_i.lk_idx] <= 1'b1;
    end
  end

  assign rd_width_o = rd_width_q;
  assign lk_valid_o = valid_q[req_i.lk_idx];

endmodule

[rtl/tats_tab_rem.sv]
module tats_tab_rem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tats_pkg::POS_BITS-1:0] dividend_i,
  input  logic [tats_pkg::TAB_BITS-1:0] divisor_i,
  output tats_pkg::rem_stat_t           stat_o
);
  import tats_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_BITS-1:0]   sh_q, sh_d;
  logic [TAB_BITS-1:0]   rem_q, rem_d;
  logic [TAB_BITS-1:0]   div_q, div_d;
  logic [TAB_BITS:0]     trial;

  // One restoring step per cycle, dividend bits enter MSB first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, sh_q[POS_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_CNT_W'(POS_BITS);
      sh_d   = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = TAB_BITS'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[TAB_BITS-1:0];
      end
      sh_d  = {sh_q[POS_BITS-2:0], 1'b0};
      cnt_d = cnt_q - STEP_CNT_W'(1);
      if (cnt_q == STEP_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

[rtl/text_advance_with_tab_stops.sv]
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  --------------------------------
// in        input      in_valid_i/in_stall_o  in_item_i  (opcode, code, width)
// out       output     out_valid_o/out_stall_i out_item_o (advance, position..)
// config    input      psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// An item passes through IDLE, which takes the transfer, LOOKUP, which reads
// the glyph store and stages the advance, and UPDATE, which commits the
// position. A tab item goes through DIVIDE between LOOKUP and UPDATE, while the
// remainder unit runs its restoring steps over the position bits until done.
// Reset clears the glyph presence bits at once; no clearing pass is needed.
// Input stalls outside IDLE; UPDATE holds while a stalled result fills the output register.
module text_advance_with_tab_stops (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tats_pkg::in_item_t                 in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tats_pkg::out_item_t                out_item_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tats_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [tats_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [tats_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);
  import tats_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [GW_BITS-1:0]  spacing_q;
  logic [GW_BITS-1:0]  space_adv_q;
  logic [TAB_BITS-1:0] tab_width_q;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  // Item held while it is worked on
  logic [OP_BITS-1:0]   op_q;
  logic [CODE_BITS-1:0] code_q;
  logic [GW_BITS-1:0]   gw_q;
  logic [ADV_BITS-1:0]  adv_q, adv_d;
  logic                 known_q, known_d;

  // Line state
  logic [POS_BITS-1:0] line_x_q, line_x_d;
  logic                ovf_q, ovf_d;
  logic [GW_BITS-1:0]  widest_q, widest_d;

  // Output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  logic                in_xfer;
  logic                out_free;
  logic                commit;
  glyph_req_t          glyph_req;
  logic [GW_BITS-1:0]  rd_width;
  logic                lk_valid;
  logic                in_range;
  logic                known_now;
  logic                zero_code;
  logic                rem_start;
  rem_stat_t           rem_stat;
  logic [TAB_BITS-1:0] tab_eff;
  logic [POS_BITS:0]   pos_sum;
  logic [ADV_BITS-1:0] added;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = (state_q == ST_UPDATE) && out_free;

  // ---------------------------------------------------------------------------
  // Configuration port: zero wait states, writes land in the access phase
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      REG_GLYPH_SPACING:  prdata = CFG_DATA_BITS'(spacing_q);
      REG_SPACE_ADVANCE:  prdata = CFG_DATA_BITS'(space_adv_q);
      REG_TAB_STOP_WIDTH: prdata = CFG_DATA_BITS'(tab_width_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= SPACING_RST;
      space_adv_q <= SPACE_RST;
      tab_width_q <= TAB_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GLYPH_SPACING:  spacing_q   <= pwdata[GW_BITS-1:0];
        REG_SPACE_ADVANCE:  space_adv_q <= pwdata[GW_BITS-1:0];
        REG_TAB_STOP_WIDTH: tab_width_q <= pwdata[TAB_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A zero tab width behaves as a width of one
  assign tab_eff = (tab_width_q == '0) ? TAB_BITS'(1) : tab_width_q;

  // ---------------------------------------------------------------------------
  // Glyph store: read issued on the input transfer, data valid in LOOKUP.
  // A write in LOOKUP always lands before the next item's read, so no
  // forwarding is needed.
  // ---------------------------------------------------------------------------
  assign in_range  = code_q < CODE_BITS'(GLYPHS);
  assign known_now = in_range && lk_valid;
  assign zero_code = (code_q == CH_NUL) || (code_q == CH_LF) || (code_q == CH_CR) ||
                     (code_q >= CH_PLANE1);

  always_comb begin
    glyph_req.rd_en    = in_xfer;
    glyph_req.rd_idx   = in_item_i.char_code[GLYPH_IDX_W-1:0];
    glyph_req.lk_idx   = code_q[GLYPH_IDX_W-1:0];
    glyph_req.wr_width = gw_q;
    // Only the first registration of a code sticks
    glyph_req.wr_en    = (state_q == ST_LOOKUP) && (op_q == OP_REGISTER) &&
                         in_range && !lk_valid;
  end

  tats_glyph_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (glyph_req),
    .rd_width_o (rd_width),
    .lk_valid_o (lk_valid)
  );

  // Tab: remainder of the position by the stop width
  assign rem_start = (state_q == ST_LOOKUP) && (op_q == OP_MEASURE) && (code_q == CH_TAB);

  tats_tab_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (line_x_q),
    .divisor_i  (tab_eff),
    .stat_o     (rem_stat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    adv_d    = adv_q;
    known_d  = known_q;
    widest_d = widest_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        adv_d   = '0;
        known_d = known_now;
        state_d = ST_UPDATE;
        if (op_q == OP_REGISTER) begin
          known_d = in_range;
          if (glyph_req.wr_en && (gw_q > widest_q)) begin
            widest_d = gw_q;
          end
        end else if (op_q == OP_MEASURE) begin
          if (code_q == CH_TAB) begin
            state_d = ST_DIVIDE;
          end else if (zero_code) begin
            adv_d = '0;
          end else if (known_now) begin
            adv_d = ADV_BITS'(rd_width) + ADV_BITS'(spacing_q);
          end else begin
            adv_d = ADV_BITS'(space_adv_q);
          end
        end
      end
      ST_DIVIDE: begin
        if (rem_stat.done) begin
          adv_d   = ADV_BITS'(tab_eff) - ADV_BITS'(rem_stat.rem);
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Position update: saturate at the top and flag it until the next new line
  always_comb begin
    pos_sum  = {1'b0, line_x_q} + (POS_BITS + 1)'(adv_q);
    line_x_d = line_x_q;
    ovf_d    = ovf_q;
    added    = '0;
    if (op_q == OP_MEASURE) begin
      if (pos_sum > {1'b0, POS_MAX}) begin
        line_x_d = POS_MAX;
        ovf_d    = 1'b1;
        added    = ADV_BITS'(POS_MAX - line_x_q);
      end else begin
        line_x_d = pos_sum[POS_BITS-1:0];
        added    = adv_q;
      end
    end else if (op_q == OP_NEWLINE) begin
      line_x_d = '0;
      ovf_d    = 1'b0;
    end
    out_d.advance           = added;
    out_d.line_position     = line_x_d;
    out_d.glyph_known       = known_q;
    out_d.position_overflow = ovf_d;
    out_d.widest_width      = widest_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_x_q    <= '0;
      ovf_q       <= 1'b0;
      widest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      widest_q <= widest_d;
      if (commit) begin
        line_x_q    <= line_x_d;
        ovf_q       <= ovf_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item, stage the advance, load the result
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q   <= in_item_i.opcode;
      code_q <= in_item_i.char_code;
      gw_q   <= in_item_i.glyph_width_in;
    end
    adv_q   <= adv_d;
    known_q <= known_d;
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ovf_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (line_x_q == POS_MAX))
    else $error("overflow flag set below the maximum position");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (op_q != OP_NEWLINE)) |=> (line_x_q >= $past(line_x_q)))
    else $error("line position moved backward without a new line");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && rem_stat.done) |-> (rem_stat.rem < tab_eff))
    else $error("tab remainder not below the stop width");

  a_store_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    glyph_req.wr_en |-> !lk_valid)
    else $error("glyph entry written twice");

endmodule
